>>> rtl/core/snba_pkg.sv
package snba_pkg;

  localparam int unsigned MaxExtent = 4096;
  localparam int unsigned ExtW      = 13;  // grid extent register width
  localparam int unsigned CoordW    = 12;  // resolved row/column width
  localparam int unsigned ModW      = 14;  // holds 2*MaxExtent-2
  localparam int unsigned MagW      = 32;  // magnitude of a shifted coordinate
  localparam int unsigned BitsPerStg = 4;
  localparam int unsigned RemStages = MagW / BitsPerStg;

  typedef enum logic [2:0] {
    CFG_BOUNDARY_MODE = 3'd0,
    CFG_NBR_KIND      = 3'd1,
    CFG_GRID_WIDTH    = 3'd2,
    CFG_GRID_HEIGHT   = 3'd3,
    CFG_FIXED_VALUE   = 3'd4
  } cfg_idx_e;

  typedef enum logic [1:0] {
    BND_WRAP    = 2'd0,
    BND_REFLECT = 2'd1,
    BND_FIXED   = 2'd2,
    BND_CLAMP   = 2'd3
  } bnd_mode_e;

  typedef enum logic [1:0] {
    NBR_FOUR   = 2'd0,
    NBR_EIGHT  = 2'd1,
    NBR_TWELVE = 2'd2,
    NBR_TWENTY_FOUR = 2'd3
  } nbr_kind_e;

  typedef struct packed {
    logic signed [2:0] dx;
    logic signed [2:0] dy;
  } off_t;

  // One coordinate travelling through the remainder pipeline.
  typedef struct packed {
    logic            neg;
    logic [MagW-1:0] mag;
    logic [ModW-1:0] rem;
    logic [ModW-1:0] n;
  } rem_t;

  localparam logic signed [2:0] NearDx [12] =
    '{3'sd0, 3'sd0, 3'sd1, -3'sd1, 3'sd1, -3'sd1, 3'sd1, -3'sd1, 3'sd0, 3'sd0, 3'sd2, -3'sd2};
  localparam logic signed [2:0] NearDy [12] =
    '{-3'sd1, 3'sd1, 3'sd0, 3'sd0, -3'sd1, -3'sd1, 3'sd1, 3'sd1, -3'sd2, 3'sd2, 3'sd0, 3'sd0};
  // Row-major 5x5 block with the centre skipped.
  localparam logic signed [2:0] FullDx [24] =
    '{-3'sd2, -3'sd1, 3'sd0, 3'sd1, 3'sd2, -3'sd2, -3'sd1, 3'sd0, 3'sd1, 3'sd2,
      -3'sd2, -3'sd1, 3'sd1, 3'sd2, -3'sd2, -3'sd1, 3'sd0, 3'sd1, 3'sd2,
      -3'sd2, -3'sd1, 3'sd0, 3'sd1, 3'sd2};
  localparam logic signed [2:0] FullDy [24] =
    '{-3'sd2, -3'sd2, -3'sd2, -3'sd2, -3'sd2, -3'sd1, -3'sd1, -3'sd1, -3'sd1, -3'sd1,
      3'sd0, 3'sd0, 3'sd0, 3'sd0, 3'sd1, 3'sd1, 3'sd1, 3'sd1, 3'sd1,
      3'sd2, 3'sd2, 3'sd2, 3'sd2, 3'sd2};

  function automatic off_t nbr_offset(input logic [1:0] kind, input logic [4:0] idx);
    off_t o;
    o.dx = 3'sd0;
    o.dy = 3'sd0;
    case (kind)
      NBR_FOUR: begin
        if (idx < 5'd4) begin
          o.dx = NearDx[idx[3:0]];
          o.dy = NearDy[idx[3:0]];
        end
      end
      NBR_EIGHT: begin
        if (idx < 5'd8) begin
          o.dx = NearDx[idx[3:0]];
          o.dy = NearDy[idx[3:0]];
        end
      end
      NBR_TWELVE: begin
        if (idx < 5'd12) begin
          o.dx = NearDx[idx[3:0]];
          o.dy = NearDy[idx[3:0]];
        end
      end
      default: begin
        if (idx < 5'd24) begin
          o.dx = FullDx[idx];
          o.dy = FullDy[idx];
        end
      end
    endcase
    return o;
  endfunction

  // Four restoring remainder steps, most significant magnitude bits first.
  function automatic rem_t rem_step(input rem_t s);
    rem_t o;
    logic [ModW-1:0] r;
    o = s;
    for (int i = 0; i < BitsPerStg; i++) begin
      r     = {o.rem[ModW-2:0], o.mag[MagW-1]};
      o.mag = {o.mag[MagW-2:0], 1'b0};
      if (r >= o.n) r = r - o.n;
      o.rem = r;
    end
    return o;
  endfunction

endpackage

>>> rtl/core/snba_rem_pipe.sv
module snba_rem_pipe (
  input  logic                                clk_i,
  input  logic [snba_pkg::RemStages-1:0]      en_i,
  input  snba_pkg::rem_t                      in_i,
  output snba_pkg::rem_t                      out_o
);
  import snba_pkg::*;

  rem_t stg_q [RemStages];

  // Each stage resolves four magnitude bits of the remainder.
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < RemStages; k++) begin
      if (en_i[k]) begin
        stg_q[k] <= (k == 0) ? rem_step(in_i) : rem_step(stg_q[(k == 0) ? 0 : k - 1]);
      end
    end
  end

  assign out_o = stg_q[RemStages-1];

endmodule

>>> rtl/core/stencil_neighbor_boundary_address.sv
// Channel   Direction  Handshake                  Payload
// ------    ---------  -------------------------  -------------------------------------
// in        sink       in_valid_i / in_stall_o    coord_x_i, coord_y_i, neighbor_index_i
// out       source     out_valid_o / out_stall_i  column_o, row_o, address_o,
//                                                 use_fixed_o, fixed_value_o
// cfg       sink       cfg_we_i (no wait)         cfg_index_i, cfg_data_i
//
// One transaction can enter every cycle while the pipeline is not stalled. Its result is
// registered in turn by the input register, the eight-stage remainder pipeline that resolves wrap
// and reflect (four bits a stage), the select stage and the output register.
// Reset clears all valid bits and loads the configuration defaults.
// A stage holds only when it is full and the stage after it holds, so stalls squeeze
// out bubbles and no transaction is lost or repeated.
module stencil_neighbor_boundary_address (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] coord_x_i,
  input  logic [31:0] coord_y_i,
  input  logic [4:0]  neighbor_index_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [11:0] column_o,
  output logic [11:0] row_o,
  output logic [23:0] address_o,
  output logic        use_fixed_o,
  output logic [31:0] fixed_value_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);
  import snba_pkg::*;

  // Stage 0 is the input register, stages 1..RemStages the remainder pipeline,
  // then the boundary select stage and the address/output stage.
  localparam int unsigned SelStg = RemStages + 1;
  localparam int unsigned OutStg = RemStages + 2;
  localparam int unsigned NStg   = RemStages + 3;

  typedef struct packed {
    logic              zero;
    logic              in_grid;
    logic [CoordW-1:0] x_lo;
    logic [CoordW-1:0] y_lo;
    logic [CoordW-1:0] clamp_x;
    logic [CoordW-1:0] clamp_y;
  } side_t;

  // Configuration registers.
  logic [1:0]  mode_q, kind_q;
  logic [12:0] gw_q, gh_q;
  logic [31:0] fval_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= BND_WRAP;
      kind_q <= NBR_EIGHT;
      gw_q   <= 13'd256;
      gh_q   <= 13'd256;
      fval_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_BOUNDARY_MODE: mode_q <= cfg_data_i[1:0];
        CFG_NBR_KIND:      kind_q <= cfg_data_i[1:0];
        CFG_GRID_WIDTH:    gw_q   <= cfg_data_i[12:0];
        CFG_GRID_HEIGHT:   gh_q   <= cfg_data_i[12:0];
        CFG_FIXED_VALUE:   fval_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Extents saturated at the maximum grid size.
  logic [ExtW-1:0] w_sat, h_sat;
  assign w_sat = (gw_q > ExtW'(MaxExtent)) ? ExtW'(MaxExtent) : gw_q;
  assign h_sat = (gh_q > ExtW'(MaxExtent)) ? ExtW'(MaxExtent) : gh_q;

  // Valid bits and the advance chain.
  logic [NStg-1:0] v_q;
  logic [NStg-1:0] adv;

  always_comb begin
    adv[NStg-1] = !v_q[NStg-1] || !out_stall_i;
    for (int k = NStg - 2; k >= 0; k--) begin
      adv[k] = !v_q[k] || adv[k+1];
    end
  end

  assign in_stall_o = !adv[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 0; k < NStg; k++) begin
        if (adv[k]) v_q[k] <= (k == 0) ? in_valid_i : v_q[(k == 0) ? 0 : k - 1];
      end
    end
  end

  // Stage 0: input register.
  logic [31:0] cx_q, cy_q;
  logic [4:0]  idx_q;

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      cx_q  <= coord_x_i;
      cy_q  <= coord_y_i;
      idx_q <= neighbor_index_i;
    end
  end

  // Offset add, grid test, clamp and modulus selection feed the remainder pipeline.
  off_t              off;
  logic signed [32:0] px, py;
  logic              x_out, y_out;
  side_t             side_in;
  rem_t              rx_in, ry_in;
  logic [ModW-1:0]   nx, ny;

  always_comb begin
    off = nbr_offset(kind_q, idx_q);
    px  = $signed({cx_q[31], cx_q}) + 33'($signed(off.dx));
    py  = $signed({cy_q[31], cy_q}) + 33'($signed(off.dy));

    x_out = px[32] || (px >= $signed({20'd0, w_sat}));
    y_out = py[32] || (py >= $signed({20'd0, h_sat}));

    side_in.zero    = (w_sat == '0) || (h_sat == '0);
    side_in.in_grid = !x_out && !y_out;
    side_in.x_lo    = px[CoordW-1:0];
    side_in.y_lo    = py[CoordW-1:0];
    side_in.clamp_x = px[32] ? '0 : (x_out ? CoordW'(w_sat - 1'b1) : px[CoordW-1:0]);
    side_in.clamp_y = py[32] ? '0 : (y_out ? CoordW'(h_sat - 1'b1) : py[CoordW-1:0]);

    // Reflect folds over a period of 2n-2; a one-cell extent maps everything to zero.
    if (mode_q == BND_REFLECT) begin
      nx = (w_sat <= 13'd1) ? ModW'(1) : ModW'({w_sat, 1'b0} - 14'd2);
      ny = (h_sat <= 13'd1) ? ModW'(1) : ModW'({h_sat, 1'b0} - 14'd2);
    end else begin
      nx = ModW'(w_sat);
      ny = ModW'(h_sat);
    end

    rx_in.neg = px[32];
    rx_in.mag = px[32] ? MagW'(-px) : px[MagW-1:0];
    rx_in.rem = '0;
    rx_in.n   = nx;
    ry_in.neg = py[32];
    ry_in.mag = py[32] ? MagW'(-py) : py[MagW-1:0];
    ry_in.rem = '0;
    ry_in.n   = ny;
  end

  // Remainder pipelines for both coordinates, with the side data alongside.
  rem_t rx_out, ry_out;

  snba_rem_pipe u_rem_x (
    .clk_i (clk_i),
    .en_i  (adv[RemStages:1]),
    .in_i  (rx_in),
    .out_o (rx_out)
  );

  snba_rem_pipe u_rem_y (
    .clk_i (clk_i),
    .en_i  (adv[RemStages:1]),
    .in_i  (ry_in),
    .out_o (ry_out)
  );

  side_t side_q [RemStages];

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < RemStages; k++) begin
      if (adv[k+1]) side_q[k] <= (k == 0) ? side_in : side_q[(k == 0) ? 0 : k - 1];
    end
  end

  // Select stage: true modulo, reflection fold and boundary mode choice.
  logic [ModW-1:0]   mx, my, fx, fy;
  logic [CoordW-1:0] sel_x, sel_y;
  logic              sel_fixed;
  side_t             s_last;

  always_comb begin
    s_last = side_q[RemStages-1];
    mx = (rx_out.neg && rx_out.rem != '0) ? rx_out.n - rx_out.rem : rx_out.rem;
    my = (ry_out.neg && ry_out.rem != '0) ? ry_out.n - ry_out.rem : ry_out.rem;
    fx = (mx >= ModW'(w_sat)) ? rx_out.n - mx : mx;
    fy = (my >= ModW'(h_sat)) ? ry_out.n - my : my;

    sel_fixed = 1'b0;
    sel_x     = s_last.x_lo;
    sel_y     = s_last.y_lo;
    if (s_last.zero) begin
      sel_fixed = 1'b1;
    end else if (!s_last.in_grid) begin
      case (mode_q)
        BND_WRAP: begin
          sel_x = mx[CoordW-1:0];
          sel_y = my[CoordW-1:0];
        end
        BND_REFLECT: begin
          sel_x = fx[CoordW-1:0];
          sel_y = fy[CoordW-1:0];
        end
        BND_FIXED: sel_fixed = 1'b1;
        default: begin
          sel_x = s_last.clamp_x;
          sel_y = s_last.clamp_y;
        end
      endcase
    end
  end

  logic [CoordW-1:0] col_q, row_q;
  logic              fix_q;

  always_ff @(posedge clk_i) begin
    if (adv[SelStg]) begin
      col_q <= sel_x;
      row_q <= sel_y;
      fix_q <= sel_fixed;
    end
  end

  // Output stage: row-major address and fixed value.
  logic [24:0] prod;
  assign prod = row_q * w_sat;

  always_ff @(posedge clk_i) begin
    if (adv[OutStg]) begin
      column_o      <= fix_q ? '0 : col_q;
      row_o         <= fix_q ? '0 : row_q;
      address_o     <= fix_q ? '0 : prod[23:0] + {12'd0, col_q};
      use_fixed_o   <= fix_q;
      fixed_value_o <= fix_q ? fval_q : '0;
    end
  end

  assign out_valid_o = v_q[OutStg];

endmodule

>>> tb/stencil_neighbor_boundary_address_checker.sv
`timescale 1ns / 100ps

module stencil_neighbor_boundary_address_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [31:0] coord_x_i,
  input  logic [31:0] coord_y_i,
  input  logic [4:0]  neighbor_index_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [11:0] column_i,
  input  logic [11:0] row_i,
  input  logic [23:0] address_i,
  input  logic        use_fixed_i,
  input  logic [31:0] fixed_value_i,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  output int          errors_o,
  output int          pending_o
);
  import snba_pkg::*;

  typedef struct packed {
    logic [11:0] column;
    logic [11:0] row;
    logic [23:0] address;
    logic        use_fixed;
    logic [31:0] fixed_value;
  } lookup_t;

  lookup_t   lookup_q[$];
  bnd_mode_e bnd_mode;
  nbr_kind_e nbr_kind;
  logic [12:0] width_reg, height_reg;
  logic [31:0] fixed_reg;

  function automatic longint fold(longint v, longint n, bit mirror);
    longint p, r;
    if (mirror && n <= 1) return 0;
    p = mirror ? 2 * n - 2 : n;
    r = v % p;
    if (r < 0) r += p;
    if (mirror && r >= n) r = p - r;
    return r;
  endfunction

  function automatic lookup_t resolve(logic [31:0] cx, logic [31:0] cy, logic [4:0] idx);
    lookup_t res;
    longint w, h, x, y, dx, dy, cnt, p;
    bit fixed;
    w = (width_reg > 4096) ? 4096 : width_reg;
    h = (height_reg > 4096) ? 4096 : height_reg;
    dx = 0;
    dy = 0;
    cnt = (nbr_kind == NBR_FOUR) ? 4 : (nbr_kind == NBR_EIGHT) ? 8 :
          (nbr_kind == NBR_TWELVE) ? 12 : 24;
    if (idx < cnt) begin
      if (nbr_kind == NBR_TWENTY_FOUR) begin
        p = (idx < 12) ? idx : idx + 1;
        dx = p % 5 - 2;
        dy = p / 5 - 2;
      end else begin
        case (idx)
          0: dy = -1;
          1: dy = 1;
          2: dx = 1;
          3: dx = -1;
          4: begin dx = 1; dy = -1; end
          5: begin dx = -1; dy = -1; end
          6: begin dx = 1; dy = 1; end
          7: begin dx = -1; dy = 1; end
          8: dy = -2;
          9: dy = 2;
          10: dx = 2;
          default: dx = -2;
        endcase
      end
    end
    x = longint'($signed(cx)) + dx;
    y = longint'($signed(cy)) + dy;
    fixed = 0;
    if (w == 0 || h == 0) begin
      fixed = 1;
    end else if (x < 0 || y < 0 || x >= w || y >= h) begin
      case (bnd_mode)
        BND_WRAP: begin x = fold(x, w, 0); y = fold(y, h, 0); end
        BND_REFLECT: begin x = fold(x, w, 1); y = fold(y, h, 1); end
        BND_FIXED: fixed = 1;
        default: begin
          x = (x < 0) ? 0 : (x > w - 1) ? w - 1 : x;
          y = (y < 0) ? 0 : (y > h - 1) ? h - 1 : y;
        end
      endcase
    end
    res = '0;
    if (fixed) begin
      res.use_fixed = 1'b1;
      res.fixed_value = fixed_reg;
    end else begin
      res.column = x[11:0];
      res.row = y[11:0];
      res.address = 24'(y * w + x);
    end
    return res;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    lookup_t got, want;
    if (!rst_ni) begin
      bnd_mode   <= BND_WRAP;
      nbr_kind   <= NBR_EIGHT;
      width_reg  <= 13'd256;
      height_reg <= 13'd256;
      fixed_reg  <= '0;
      errors_o   <= 0;
      lookup_q.delete();
    end else begin
      if (out_valid_i && !out_stall_i) begin
        got = '{column_i, row_i, address_i, use_fixed_i, fixed_value_i};
        if (lookup_q.size() == 0) begin
          if (errors_o < 10) $display("unexpected result %p", got);
          errors_o <= errors_o + 1;
        end else begin
          want = lookup_q.pop_front();
          if (got !== want) begin
            if (errors_o < 10) $display("mismatch: expected %p actual %p", want, got);
            errors_o <= errors_o + 1;
          end
        end
      end
      if (in_valid_i && !in_stall_i)
        lookup_q = {lookup_q, resolve(coord_x_i, coord_y_i, neighbor_index_i)};
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_BOUNDARY_MODE: bnd_mode <= bnd_mode_e'(cfg_data_i[1:0]);
          CFG_NBR_KIND:      nbr_kind <= nbr_kind_e'(cfg_data_i[1:0]);
          CFG_GRID_WIDTH:    width_reg <= cfg_data_i[12:0];
          CFG_GRID_HEIGHT:   height_reg <= cfg_data_i[12:0];
          CFG_FIXED_VALUE:   fixed_reg <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  assign pending_o = lookup_q.size();

endmodule

>>> tb/stencil_neighbor_boundary_address_tb.sv
`timescale 1ns / 100ps

module stencil_neighbor_boundary_address_tb;
  import snba_pkg::*;

  // The block is 11 deep; drain waits comfortably beyond that.
  localparam int Depth = 11;
  localparam int CycleLimit = 400000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [31:0] coord_x_i = '0;
  logic [31:0] coord_y_i = '0;
  logic [4:0]  neighbor_index_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [11:0] column_o, row_o;
  logic [23:0] address_o;
  logic        use_fixed_o;
  logic [31:0] fixed_value_o;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;
  int          errors, pending;
  int          cycles = 0;
  bit          calm;  // no idling on either side in the closing stretch

  always #5 clk_i = ~clk_i;

  stencil_neighbor_boundary_address u_dut (.*);

  stencil_neighbor_boundary_address_checker u_chk (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .coord_x_i, .coord_y_i,
    .neighbor_index_i, .out_valid_i(out_valid_o), .out_stall_i, .column_i(column_o),
    .row_i(row_o), .address_i(address_o), .use_fixed_i(use_fixed_o),
    .fixed_value_i(fixed_value_o), .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .errors_o(errors), .pending_o(pending)
  );

  // The run is bounded by a cycle counter; hitting it is a failure.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("stencil_neighbor_boundary_address verification failed");
      $finish;
    end
  end

  // Receiver back-pressure comes in random bursts while not in the calm stretch.
  initial begin
    int burst;
    forever begin
      @(posedge clk_i);
      if (!calm && $urandom_range(0, 5) == 0) begin
        burst = $urandom_range(1, 11);
        out_stall_i <= 1'b1;
        repeat (burst) @(posedge clk_i);
        out_stall_i <= 1'b0;
        repeat ($urandom_range(0, 8)) @(posedge clk_i);
      end
    end
  end

  // One register write, after which the write enable drops low, so back-to-back writes never
  // drive the write enable twice in one time step.
  task automatic write_reg(cfg_idx_e idx, logic [31:0] data);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Wait until every expected result is out, then let the pipeline settle.
  task automatic drain();
    while (pending != 0) @(posedge clk_i);
    repeat (Depth + 4) @(posedge clk_i);
  endtask

  // One transaction: hold the payload until the block takes it, with an
  // optional idle burst ahead of it.
  task automatic send(logic [31:0] cx, logic [31:0] cy, logic [4:0] idx);
    if (!calm && $urandom_range(0, 7) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    coord_x_i <= cx;
    coord_y_i <= cy;
    neighbor_index_i <= idx;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  // Coordinates lean toward the grid edges, with some anywhere in 32 bits.
  function automatic logic [31:0] pick_coord(int n);
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return 32'($urandom_range(0, 3)) - 32'd2;
      2: return 32'(n) + 32'($urandom_range(0, 4)) - 32'd3;
      3: return {$urandom_range(0, 1) ? 2'b10 : 2'b01, 30'($urandom())};
      default: return 32'($urandom_range(0, n + 4)) - 32'd2;
    endcase
  endfunction

  initial begin
    int w, h;
    logic [31:0] edge_vals[6];
    calm = 0;
    edge_vals = '{32'h0, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFE,
                  32'h8000_0001};
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset configuration, extremes of the coordinates and index.
    foreach (edge_vals[i]) send(edge_vals[i], edge_vals[5 - i], 5'(i * 5));
    send(32'd255, 32'd255, 5'd31);
    send(32'd0, 32'd0, 5'd7);
    in_valid_i <= 1'b0;
    drain();

    // Zero width flags the fixed value; one-cell extent under reflect.
    write_reg(CFG_FIXED_VALUE, 32'hDEAD_BEEF);
    write_reg(CFG_GRID_WIDTH, 32'd0);
    send(32'd1, 32'd1, 5'd0);
    in_valid_i <= 1'b0;
    drain();
    write_reg(CFG_BOUNDARY_MODE, BND_REFLECT);
    write_reg(CFG_GRID_WIDTH, 32'd1);
    write_reg(CFG_GRID_HEIGHT, 32'd1);
    send(32'd5, 32'hFFFF_FFFD, 5'd1);
    in_valid_i <= 1'b0;
    drain();

    // Extent above the maximum saturates; every mode and kind at large coordinates.
    write_reg(CFG_GRID_WIDTH, 32'h1FFF);
    write_reg(CFG_GRID_HEIGHT, 32'd4096);
    for (int m = 0; m < 4; m++) begin
      write_reg(CFG_BOUNDARY_MODE, m);
      write_reg(CFG_NBR_KIND, 3 - m);
      send(32'd4095, 32'd4097, 5'd23);
      send(32'h8000_0000, 32'h7FFF_FFFF, 5'd11);
      send(32'hFFFF_FFFF, 32'd0, 5'd3);
      in_valid_i <= 1'b0;
      drain();
    end

    // Random phases over a spread of configurations, small grids mostly.
    for (int phase = 0; phase < 24; phase++) begin
      case ($urandom_range(0, 5))
        0: begin w = 4096; h = $urandom_range(0, 8191); end
        1: begin w = $urandom_range(0, 3); h = $urandom_range(1, 3); end
        2: begin w = $urandom_range(1, 8191); h = $urandom_range(1, 8191); end
        default: begin w = $urandom_range(1, 40); h = $urandom_range(1, 40); end
      endcase
      write_reg(CFG_GRID_WIDTH, w);
      write_reg(CFG_GRID_HEIGHT, h);
      write_reg(CFG_BOUNDARY_MODE, $urandom_range(0, 3));
      write_reg(CFG_NBR_KIND, $urandom_range(0, 3));
      write_reg(CFG_FIXED_VALUE, $urandom());
      calm = (phase >= 21);
      repeat (50)
        send(pick_coord(w), pick_coord(h), 5'($urandom_range(0, 31)));
      in_valid_i <= 1'b0;
      // Sender holds off until every expected result has come.
      drain();
    end

    if (errors == 0) begin
      $display("stencil_neighbor_boundary_address verification clean");
    end else begin
      $display("stencil_neighbor_boundary_address verification failed");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/core/snba_pkg.sv
rtl/core/snba_rem_pipe.sv
rtl/core/stencil_neighbor_boundary_address.sv
tb/stencil_neighbor_boundary_address_checker.sv
tb/stencil_neighbor_boundary_address_tb.sv
